// ----- sv/scc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

	localparam int MAX_CUBES = 64;
	localparam int MAX_VARS  = 32;
	localparam int CUBE_W    = 64;
	localparam int AV_W      = 6;
	localparam int IDX_W     = $clog2(MAX_CUBES);
	localparam int CNT_W     = $clog2(MAX_CUBES + 1);
	localparam int LIT_W     = $clog2(MAX_VARS + 1);
	localparam int ENTRY_W   = LIT_W + CUBE_W;

	typedef struct packed {
		logic [CUBE_W-1:0] cube_bits;
		logic              last_cube;
	} cube_word_t;

	typedef struct packed {
		logic [CUBE_W-1:0] survivor_bits;
		logic              is_last;
		logic              overflow;
	} result_word_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PICK_I,
		ST_LATCH_I,
		ST_SWEEP,
		ST_EMIT_SCAN,
		ST_EMIT_LOAD
	} scc_state_t;

endpackage

`default_nettype wire

// ----- sv/single_cube_containment_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// single cube containment purge. cubes arrive one word per cycle on the cube channel (two bits
// per variable, 01/10 literal, 11 don't care) and are masked to active_vars pairs and stored
// with their literal count in a single-port-read ram; cubes past MAX_CUBES are dropped and set
// the overflow flag. the deletion marks live in a second small ram, and a cube's mark is
// cleared as the cube is stored. the word carrying last_cube starts the purge: each cube i, in
// load order, is read with its mark, and when it is still live every stored cube j is streamed
// past it, and j is marked deleted when it has at least as many literals and all its set bits
// lie inside i. survivors then go out in load order, one ram read per stored cube, with
// is_last on the final one; count and overflow are cleared for the next list. the purge
// and the emit are both bound by the one ram read port. the block takes no cube words
// during purge and emit; cfg writes are taken at any time and should only be issued while
// the block is idle.

module single_cube_containment_core
	import scc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [AV_W-1:0] cfg_data,
	input  wire logic         cube_valid,
	output logic              cube_ready,
	input  wire cube_word_t   cube,
	output logic              result_valid,
	input  wire logic         result_ready,
	output result_word_t      result
);

	// control state
	scc_state_t          state_q, state_d;
	logic [AV_W-1:0]     active_vars_q;
	logic [CNT_W-1:0]    n_q;          // cubes stored this list
	logic [CNT_W-1:0]    i_q;          // outer cube during purge
	logic [CNT_W-1:0]    j_q;          // sweep / emit index
	logic [CNT_W-1:0]    surv_q;       // live cubes left
	logic [CNT_W-1:0]    emit_cnt_q;   // survivors already sent
	logic                ovf_q;
	logic                vld_s1;       // ram data for j_s1 is present
	logic [IDX_W-1:0]    j_s1;

	// outer cube held while the sweep streams past it
	logic [CUBE_W-1:0]   cube_i_q;
	logic [LIT_W-1:0]    lit_i_q;

	// ram interface
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic [ENTRY_W-1:0]  rd_data;
	logic                wr_en;
	logic [ENTRY_W-1:0]  wr_data;
	logic [CUBE_W-1:0]   rd_cube;
	logic [LIT_W-1:0]    rd_lit;

	// deletion mark ram, read alongside the cube store
	logic                mark_wr_en;
	logic [IDX_W-1:0]    mark_wr_addr;
	logic                mark_wr_data;
	logic                mark_rd_data;

	// load-side datapath
	logic [AV_W-1:0]     vars_eff;
	logic [CUBE_W-1:0]   var_mask;
	logic [CUBE_W-1:0]   cube_masked;
	logic [CUBE_W/2-1:0] lit_flags;
	logic [LIT_W-1:0]    lit_new;
	logic                cube_acc;
	logic                room;
	logic [CNT_W-1:0]    n_next;

	// sweep compare
	logic                hit;

	assign cfg_ready = 1'b1;

	assign rd_cube = rd_data[CUBE_W-1:0];
	assign rd_lit  = rd_data[ENTRY_W-1:CUBE_W];

	// out-of-range variable counts clamp to 1..MAX_VARS
	always_comb begin
		vars_eff = active_vars_q;
		if (active_vars_q == '0) begin
			vars_eff = AV_W'(1);
		end else if (active_vars_q > AV_W'(MAX_VARS)) begin
			vars_eff = AV_W'(MAX_VARS);
		end
	end

	// one enable per variable pair, then literal flags (01 or 10) per pair
	always_comb begin
		for (int k = 0; k < CUBE_W / 2; k++) begin
			var_mask[2*k +: 2] = (k < int'(vars_eff)) ? 2'b11 : 2'b00;
		end
		cube_masked = cube.cube_bits & var_mask;
		for (int k = 0; k < CUBE_W / 2; k++) begin
			lit_flags[k] = cube_masked[2*k] ^ cube_masked[2*k+1];
		end
		lit_new = LIT_W'($countones(lit_flags));
	end

	assign cube_acc = cube_valid && cube_ready;
	assign room     = (n_q < CNT_W'(MAX_CUBES));
	assign n_next   = room ? (n_q + CNT_W'(1)) : n_q;
	assign wr_en    = cube_acc && room;
	assign wr_data  = {lit_new, cube_masked};

	scc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_CUBES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (n_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// a stored cube starts live, a sweep hit marks it deleted
	assign mark_wr_en   = wr_en || hit;
	assign mark_wr_addr = hit ? j_s1 : n_q[IDX_W-1:0];
	assign mark_wr_data = hit;

	scc_ram #(
		.WIDTH (1),
		.DEPTH (MAX_CUBES)
	) u_marks (
		.clk     (clk),
		.wr_en   (mark_wr_en),
		.wr_addr (mark_wr_addr),
		.wr_data (mark_wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (mark_rd_data)
	);

	// j is inside cube i: not i itself, still live, no fewer literals, no bit outside i
	assign hit = vld_s1 && (j_s1 != i_q[IDX_W-1:0]) && !mark_rd_data &&
		(rd_lit >= lit_i_q) && ((rd_cube & ~cube_i_q) == '0);

	// sequencer: next state and ram read control
	always_comb begin
		state_d    = state_q;
		cube_ready = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		unique case (state_q)
			ST_LOAD: begin
				cube_ready = 1'b1;
				if (cube_acc && cube.last_cube) begin
					state_d = ST_PICK_I;
				end
			end
			ST_PICK_I: begin
				if (i_q == n_q) begin
					state_d = ST_EMIT_SCAN;
				end else begin
					rd_en   = 1'b1;
					rd_addr = i_q[IDX_W-1:0];
					state_d = ST_LATCH_I;
				end
			end
			ST_LATCH_I: begin
				// a deleted outer cube is skipped
				state_d = mark_rd_data ? ST_PICK_I : ST_SWEEP;
			end
			ST_SWEEP: begin
				if (j_q < n_q) begin
					rd_en   = 1'b1;
					rd_addr = j_q[IDX_W-1:0];
				end else if (!vld_s1) begin
					state_d = ST_PICK_I;
				end
			end
			ST_EMIT_SCAN: begin
				if (j_q == n_q) begin
					state_d = ST_LOAD;
				end else if (!result_valid || result_ready) begin
					rd_en   = 1'b1;
					rd_addr = j_q[IDX_W-1:0];
					state_d = ST_EMIT_LOAD;
				end
			end
			ST_EMIT_LOAD: begin
				state_d = ST_EMIT_SCAN;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_vars_q <= AV_W'(MAX_VARS);
			n_q           <= '0;
			i_q           <= '0;
			j_q           <= '0;
			surv_q        <= '0;
			emit_cnt_q    <= '0;
			ovf_q         <= 1'b0;
			vld_s1        <= 1'b0;
			j_s1          <= '0;
			result_valid  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				active_vars_q <= cfg_data;
			end

			if (result_valid && result_ready) begin
				result_valid <= 1'b0;
			end

			// sweep compare stage, one stored cube per cycle
			if (hit) begin
				surv_q <= surv_q - CNT_W'(1);
			end

			unique case (state_q)
				ST_LOAD: begin
					if (cube_acc) begin
						n_q <= n_next;
						if (!room) begin
							ovf_q <= 1'b1;
						end
						if (cube.last_cube) begin
							i_q    <= '0;
							surv_q <= n_next;
						end
					end
				end
				ST_PICK_I: begin
					if (i_q == n_q) begin
						j_q        <= '0;
						emit_cnt_q <= '0;
					end
				end
				ST_LATCH_I: begin
					j_q <= '0;
					if (mark_rd_data) begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				ST_SWEEP: begin
					vld_s1 <= (j_q < n_q);
					j_s1   <= j_q[IDX_W-1:0];
					if (j_q < n_q) begin
						j_q <= j_q + CNT_W'(1);
					end else if (!vld_s1) begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				ST_EMIT_SCAN: begin
					if (j_q == n_q) begin
						// list done, ready for the next one
						n_q   <= '0;
						ovf_q <= 1'b0;
					end
				end
				ST_EMIT_LOAD: begin
					if (!mark_rd_data) begin
						result_valid <= 1'b1;
						emit_cnt_q   <= emit_cnt_q + CNT_W'(1);
					end
					j_q <= j_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// outer cube capture, data arrives the cycle after its read
	always_ff @(posedge clk) begin
		if (state_q == ST_LATCH_I) begin
			cube_i_q <= rd_cube;
			lit_i_q  <= rd_lit;
		end
	end

	// output word register, loaded only when the previous word is gone
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LOAD && !mark_rd_data) begin
			result.survivor_bits <= rd_cube;
			result.is_last       <= (emit_cnt_q == CNT_W'(surv_q - CNT_W'(1)));
			result.overflow      <= ovf_q;
		end
	end

endmodule

`default_nettype wire

// ----- sv/scc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module scc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import scc_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000; // idle cycles
	localparam int PARK_CYCLES    = 600;   // long receiver hold-off
	localparam int SETTLE_CYCLES  = 16;    // after the last survivor, before a cfg write
	localparam int TAIL_CYCLES    = 40;
	localparam int PHASES         = 10;

	// derivation kinds for cubes built from earlier cubes of the same list
	typedef enum int {
		MAKE_FRESH,
		MAKE_NARROWER,
		MAKE_WIDER,
		MAKE_COPY,
		MAKE_NOISY
	} cube_kind_t;

	logic         clk;
	logic         arst_n       = 1'b0;
	logic         cfg_valid    = 1'b0;
	logic [AV_W-1:0] cfg_data  = '0;
	logic         cube_valid   = 1'b0;
	cube_word_t   cube         = '0;
	logic         result_ready = 1'b0;
	logic         cfg_ready;
	logic         cube_ready;
	logic         result_valid;
	result_word_t result;

	// stimulus side
	cube_word_t   cube_backlog [$];
	int           cubes_queued = 0;
	int           cubes_taken  = 0;
	int           send_gap     = 0;
	logic         cube_took    = 1'b0;
	bit           steady       = 1'b0;
	int           hold_asks    = 0;
	int           hold_served  = 0;
	int           park_left    = 0;

	// predictor state: current list as the block should hold it
	logic [AV_W-1:0]   vars_setting = 6'd32;
	logic [CUBE_W-1:0] list_store [$];
	bit                list_overflow = 1'b0;
	result_word_t      survivor_queue [$];

	// bookkeeping
	int error_count       = 0;
	int quiet_cycles      = 0;
	int lists_closed      = 0;
	int overflow_lists    = 0;
	int survivors_checked = 0;
	int random_vars       = 0;

	single_cube_containment_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.cube_valid   (cube_valid),
		.cube_ready   (cube_ready),
		.cube         (cube),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// load one cube into the predicted list; a last word runs the purge and queues
	// the survivors in load order
	task automatic predict_survivors(input cube_word_t w);
		int                n;
		int                v;
		int                last_live;
		logic [CUBE_W-1:0] mask;
		logic [1:0]        pr;
		bit                gone [MAX_CUBES];
		int                lits [MAX_CUBES];
		result_word_t      r;
		v = int'(vars_setting);
		if (v == 0) v = 1; // zero vars behaves as one
		if (v > MAX_VARS) v = MAX_VARS; // clamp above the pair count
		mask = (v >= 32) ? '1 : ((64'd1 << (2 * v)) - 64'd1);
		if (list_store.size() < MAX_CUBES) begin
			list_store.push_back(w.cube_bits & mask);
		end else begin
			list_overflow = 1'b1; // dropped, but a last word still closes the list
		end
		if (w.last_cube) begin
			n = list_store.size();
			for (int i = 0; i < n; i++) begin
				gone[i] = 1'b0;
				lits[i] = 0;
				for (int k = 0; k < 32; k++) begin
					pr = list_store[i][2*k +: 2];
					// 00 is an empty pair and counts as no literal
					if (pr == 2'b01 || pr == 2'b10) lits[i]++;
				end
			end
			// outer pass in load order, so the earlier of two equal cubes wins
			for (int i = 0; i < n; i++) begin
				if (!gone[i]) begin
					for (int j = 0; j < n; j++) begin
						if (j != i && !gone[j] && lits[j] >= lits[i] &&
								(list_store[j] & ~list_store[i]) == '0) begin
							gone[j] = 1'b1;
						end
					end
				end
			end
			last_live = -1;
			for (int i = 0; i < n; i++) begin
				if (!gone[i]) last_live = i;
			end
			for (int i = 0; i < n; i++) begin
				if (!gone[i]) begin
					r.survivor_bits = list_store[i];
					r.is_last       = (i == last_live);
					r.overflow      = list_overflow;
					survivor_queue.push_back(r);
				end
			end
			lists_closed++;
			if (list_overflow) overflow_lists++;
			list_store.delete();
			list_overflow = 1'b0;
		end
	endtask

	// gap before the next cube word: mostly none, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// cube driver: a word holds until taken, then the next one comes after its gap
	always @(negedge clk) begin
		cube_word_t next_word;
		logic       next_valid;
		next_word  = cube;
		next_valid = cube_valid;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else if (!cube_valid || cube_took) begin
			next_valid = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
			end else if (cube_backlog.size() > 0) begin
				next_word  = cube_backlog.pop_front();
				next_valid = 1'b1;
				send_gap   = pick_gap();
			end
		end
		cube       <= next_word;
		cube_valid <= next_valid;
	end

	// result receiver: random stalls, short bursts of long ones, and a forced park
	// when the stimulus asks for one
	always @(negedge clk) begin
		logic next_ready;
		int   r;
		r = $urandom_range(0, 99);
		if (!arst_n) begin
			next_ready = 1'b0;
		end else if (hold_asks != hold_served) begin
			hold_served++;
			park_left  = PARK_CYCLES;
			next_ready = 1'b0;
		end else if (park_left > 0) begin
			park_left--;
			next_ready = 1'b0;
		end else if (steady) begin
			next_ready = 1'b1;
		end else if (r < 4) begin
			park_left  = $urandom_range(10, 50);
			next_ready = 1'b0;
		end else begin
			next_ready = (r >= 30);
		end
		result_ready <= next_ready;
	end

	// monitor: every handshake is seen here at the rising edge
	always @(posedge clk) begin
		result_word_t want;
		bit           moved;
		cube_took <= cube_valid && cube_ready;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				vars_setting = cfg_data;
				moved = 1'b1;
			end
			if (cube_valid && cube_ready) begin
				cubes_taken++;
				predict_survivors(cube);
				moved = 1'b1;
			end
			if (result_valid && result_ready) begin
				moved = 1'b1;
				if (survivor_queue.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, result);
					error_count++;
				end else begin
					want = survivor_queue.pop_front();
					survivors_checked++;
					if (result.survivor_bits !== want.survivor_bits) begin
						$display("%0t: survivor_bits expected %h got %h", $time,
							want.survivor_bits, result.survivor_bits);
						error_count++;
					end
					if (result.is_last !== want.is_last) begin
						$display("%0t: is_last expected %b got %b", $time,
							want.is_last, result.is_last);
						error_count++;
					end
					if (result.overflow !== want.overflow) begin
						$display("%0t: overflow expected %b got %b", $time,
							want.overflow, result.overflow);
						error_count++;
					end
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d results pending", $time,
					quiet_cycles, survivor_queue.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic offer(input logic [CUBE_W-1:0] bits, input logic last);
		cube_word_t w;
		w.cube_bits = bits;
		w.last_cube = last;
		cube_backlog.push_back(w);
		cubes_queued++;
	endtask

	// one list of len cubes, many of them narrower, wider or equal copies of earlier
	// ones so that containment actually happens
	task automatic offer_list(input int len);
		logic [CUBE_W-1:0] made [$];
		logic [CUBE_W-1:0] c;
		logic [1:0]        pr;
		cube_kind_t        kind;
		int                r;
		for (int idx = 0; idx < len; idx++) begin
			r = $urandom_range(0, 99);
			if (made.size() == 0 || r < 35) kind = MAKE_FRESH;
			else if (r < 60) kind = MAKE_NARROWER;
			else if (r < 80) kind = MAKE_WIDER;
			else if (r < 90) kind = MAKE_COPY;
			else kind = MAKE_NOISY;
			if (kind != MAKE_FRESH) c = made[$urandom_range(0, made.size() - 1)];
			for (int k = 0; k < 32; k++) begin
				pr = c[2*k +: 2];
				case (kind)
					MAKE_FRESH: begin
						r = $urandom_range(0, 15);
						pr = (r == 0) ? 2'b00 : (r < 6) ? 2'b01 : (r < 11) ? 2'b10 : 2'b11;
					end
					MAKE_NARROWER: begin
						if (pr == 2'b11 && $urandom_range(0, 2) == 0)
							pr = $urandom_range(0, 1) ? 2'b01 : 2'b10;
					end
					MAKE_WIDER: begin
						if ((pr == 2'b01 || pr == 2'b10) && $urandom_range(0, 2) == 0)
							pr = 2'b11;
					end
					MAKE_NOISY: begin
						if ($urandom_range(0, 15) == 0) pr = pr ^ 2'($urandom_range(1, 3));
					end
					default: begin
					end
				endcase
				c[2*k +: 2] = pr;
			end
			made.push_back(c);
			offer(c, idx == len - 1);
		end
	endtask

	// pause the sender until the block is drained and quiet
	task automatic settle_block();
		do @(negedge clk); while (cubes_taken != cubes_queued || survivor_queue.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_vars(input logic [AV_W-1:0] value);
		@(negedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [AV_W-1:0] setting;
		int              len;
		int              r;
		int              phase_items;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed lists at the reset setting of all 32 vars
		offer('1, 1'b1);                               // single all don't-care cube
		offer('0, 1'b0);                               // all empty pairs, inside all ones
		offer('1, 1'b1);
		offer({32{2'b01}}, 1'b0);                      // identical cubes, first survives
		offer({32{2'b10}}, 1'b0);
		offer({32{2'b01}}, 1'b1);
		offer(64'hFFFF_FFFF_FFFF_FFE5, 1'b0);          // narrow before wide
		offer(64'hFFFF_FFFF_FFFF_FFF5, 1'b0);
		offer(64'hFFFF_FFFF_FFFF_FFFA, 1'b1);
		offer(64'hFFFF_FFFF_FFFF_FFF5, 1'b0);          // wide before narrow, then a copy
		offer(64'hFFFF_FFFF_FFFF_FFE5, 1'b0);
		offer(64'hFFFF_FFFF_FFFF_FFF5, 1'b1);
		offer(64'hFFFF_FFFF_FFFF_0000, 1'b0);          // empty pairs as plain bits
		offer(64'hFFFF_FFFF_0000_0000, 1'b0);
		offer(64'h0000_0000_0000_0001, 1'b1);
		offer({$urandom(), $urandom()}, 1'b1);
		settle_block();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: setting = 6'd32;
				1: setting = 6'd1;
				2: setting = 6'd0;                     // out of range low, acts as one
				3: setting = 6'd63;                    // out of range high, clamps to 32
				4: setting = 6'd33;
				5: setting = 6'd2;
				6: setting = 6'd17;
				7: begin
					random_vars = $urandom_range(3, 31);
					setting = AV_W'(random_vars);
				end
				8: setting = 6'd6;
				default: setting = 6'd32;
			endcase
			write_vars(setting);
			steady = (p % 3 == 1);
			case (p)
				0: begin
					// park the receiver while a list with many survivors drains; the
					// next lists keep offering words so the input stalls behind it
					hold_asks++;
					offer_list(12);
				end
				1: offer_list(MAX_CUBES);              // exactly full, no overflow
				3: offer_list(66);                     // up to 64 survivors and overflow
				4: offer_list(67);
				default: begin
				end
			endcase
			phase_items = 0;
			while (phase_items < 16) begin
				r = $urandom_range(0, 99);
				len = (r < 70) ? $urandom_range(1, 6) :
					(r < 95) ? $urandom_range(7, 14) : $urandom_range(15, 30);
				offer_list(len);
				phase_items += len;
			end
			settle_block();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("run: %0d cubes in %0d lists, %0d survivors checked, %0d lists overflowed",
			cubes_taken, lists_closed, survivors_checked, overflow_lists);
		$display("active_vars went through 32 1 0 63 33 2 17 %0d 6 32", random_vars);
		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
